// ===== hdl/rat_pkg.sv =====
package rat_pkg;

  localparam int SLOTS = 32;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ENTRY_W = 16 + 32 + 8;

  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_RECV = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [2:0] KIND_SENT = 3'd0;
  localparam logic [2:0] KIND_RECV = 3'd1;
  localparam logic [2:0] KIND_RETX = 3'd2;
  localparam logic [2:0] KIND_GIVEUP = 3'd3;
  localparam logic [2:0] KIND_TICK = 3'd4;

  localparam logic [0:0] REG_RETRY_INTERVAL = 1'b0;
  localparam logic [0:0] REG_RETRY_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEND,
    ST_ACK_RD,
    ST_ACK_CHK,
    ST_RECV_DONE,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic do_send;
    logic ack_rd;
    logic ack_chk;
    logic tick_start;
    logic tick_rd;
    logic tick_chk;
    logic idx_inc;
    logic emit_final;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic idx_done;
    logic emit_slot;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== hdl/rat_ram.sv =====
module rat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rat_ctrl.sv =====
module rat_ctrl
  import rat_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (stat.command)
            CMD_SEND: state_nxt = ST_SEND;
            CMD_RECV: state_nxt = ST_ACK_RD;
            CMD_TICK: state_nxt = ST_TICK_RD;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEND: if (!stat.out_busy) state_nxt = ST_OUT;
      ST_ACK_RD: state_nxt = ST_ACK_CHK;
      ST_ACK_CHK: state_nxt = stat.idx_done ? ST_RECV_DONE : ST_ACK_RD;
      ST_RECV_DONE: if (!stat.out_busy) state_nxt = ST_OUT;
      ST_TICK_RD: state_nxt = ST_TICK_CHK;
      ST_TICK_CHK: begin
        if (!(stat.emit_slot && stat.out_busy)) begin
          state_nxt = stat.idx_done ? ST_RECV_DONE : ST_TICK_RD;
        end
      end
      ST_OUT: if (!stat.out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        cmd.tick_start = in_valid && (stat.command == CMD_TICK);
      end
      ST_SEND: cmd.do_send = !stat.out_busy;
      ST_ACK_RD: cmd.ack_rd = 1'b1;
      ST_ACK_CHK: begin
        cmd.ack_chk = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      ST_RECV_DONE: cmd.emit_final = !stat.out_busy;
      ST_TICK_RD: cmd.tick_rd = 1'b1;
      ST_TICK_CHK: begin
        if (!(stat.emit_slot && stat.out_busy)) begin
          cmd.tick_chk = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

endmodule

// ===== hdl/rat_dp.sv =====
module rat_dp
  import rat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic [1:0]  in_command,
  input  logic        in_reliable,
  input  logic [15:0] in_peer_seq,
  input  logic [15:0] in_ack_number,
  input  logic [31:0] in_ack_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [15:0] out_seq,
  output logic [4:0]  out_slot,
  output logic [15:0] out_header_ack,
  output logic [31:0] out_header_ack_mask,
  output logic [31:0] out_overrun_total,
  output logic [5:0]  out_pending_count,
  output logic        out_last
);

  logic [15:0] interval_r;
  logic [7:0]  limit_r;
  logic [1:0]  cmd_r;
  logic        rel_r;
  logic [15:0] peer_r, ackn_r;
  logic [31:0] mask_r;
  logic [15:0] send_seq_r, recv_seq_r;
  logic [31:0] hist_r, overrun_r, now_r;
  logic [CNT_W-1:0] busy_cnt_r;
  logic [SLOTS-1:0] busy_r;
  // Ack walk runs 33 steps (ack number then 32 mask bits); index 0 is the number itself.
  logic [5:0]  idx_r;
  logic [5:0]  produced_r;
  logic [15:0] ack_seq_r;
  logic        ack_en_r;

  logic        ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [15:0] e_seq;
  logic [31:0] e_time;
  logic [7:0]  e_retries;
  logic [SLOT_W-1:0] scan_slot;
  logic        due;
  logic [15:0] cur_ack_seq;

  assign {e_seq, e_time, e_retries} = ram_rdata;
  assign scan_slot = idx_r[SLOT_W-1:0];
  assign due = busy_r[scan_slot] && ((now_r - e_time) >= {16'd0, interval_r})
               && (produced_r < 6'd32);
  assign cur_ack_seq = (idx_r == 6'd0) ? ackn_r : (ackn_r - 16'd1 - {10'd0, idx_r - 6'd1});

  assign stat.command = in_command;
  assign stat.out_busy = out_valid && !out_ready;
  assign stat.emit_slot = due;
  assign stat.idx_done = cmd_r == CMD_TICK ? (idx_r == 6'(SLOTS - 1)) : (idx_r == 6'd32);

  rat_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_comb begin
    ram_raddr = cmd.ack_rd ? cur_ack_seq[SLOT_W-1:0] : scan_slot;
    ram_we = 1'b0;
    ram_waddr = scan_slot;
    ram_wdata = {send_seq_r, now_r, 8'd0};
    if (cmd.do_send && rel_r) begin
      ram_we = 1'b1;
      ram_waddr = send_seq_r[SLOT_W-1:0];
    end else if (cmd.tick_chk && due && (e_retries < limit_r)) begin
      ram_we = 1'b1;
      ram_wdata = {e_seq, now_r, e_retries + 8'd1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= 16'd100;
      limit_r <= 8'd10;
    end else if (cfg_we) begin
      if (cfg_index == REG_RETRY_INTERVAL) interval_r <= cfg_wdata;
      else limit_r <= cfg_wdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      rel_r <= in_reliable;
      peer_r <= in_peer_seq;
      ackn_r <= in_ack_number;
      mask_r <= in_ack_mask;
    end
    if (cmd.ack_rd) begin
      ack_seq_r <= cur_ack_seq;
      ack_en_r <= (idx_r == 6'd0) || mask_r[idx_r[4:0] - 5'd1];
    end
  end

  logic [15:0] d;
  logic [15:0] back;
  always_comb begin
    d = peer_r - recv_seq_r;
    back = 16'd0 - d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_seq_r <= '0;
      recv_seq_r <= '0;
      hist_r <= '0;
      overrun_r <= '0;
      now_r <= '0;
      busy_cnt_r <= '0;
      busy_r <= '0;
      idx_r <= '0;
      produced_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load) begin
        idx_r <= '0;
        produced_r <= '0;
      end
      if (cmd.tick_start) now_r <= now_r + 32'd1;
      if (cmd.idx_inc) idx_r <= idx_r + 6'd1;
      if (cmd.do_send) begin
        send_seq_r <= send_seq_r + 16'd1;
        if (rel_r) begin
          if (busy_r[send_seq_r[SLOT_W-1:0]]) begin
            if (overrun_r != '1) overrun_r <= overrun_r + 32'd1;
          end else begin
            busy_cnt_r <= busy_cnt_r + CNT_W'(1);
          end
          busy_r[send_seq_r[SLOT_W-1:0]] <= 1'b1;
        end
        out_valid <= 1'b1;
        out_kind <= KIND_SENT;
        out_seq <= send_seq_r;
        out_slot <= rel_r ? 5'(send_seq_r[SLOT_W-1:0]) : 5'd0;
        out_header_ack <= recv_seq_r;
        out_header_ack_mask <= hist_r;
        out_overrun_total <= (rel_r && busy_r[send_seq_r[SLOT_W-1:0]] && overrun_r != '1)
                             ? overrun_r + 32'd1 : overrun_r;
        out_pending_count <= 6'((rel_r && !busy_r[send_seq_r[SLOT_W-1:0]])
                             ? busy_cnt_r + CNT_W'(1) : busy_cnt_r);
        out_last <= 1'b1;
      end
      if (cmd.ack_chk && ack_en_r && busy_r[ack_seq_r[SLOT_W-1:0]] && e_seq == ack_seq_r) begin
        busy_r[ack_seq_r[SLOT_W-1:0]] <= 1'b0;
        busy_cnt_r <= busy_cnt_r - CNT_W'(1);
      end
      if (cmd.ack_chk && idx_r == 6'd32) begin
        if (d != 16'd0) begin
          if (d < 16'h8000) begin
            hist_r <= (d <= 16'd32) ? ((hist_r << d) | (32'd1 << (d - 16'd1))) : 32'd0;
            recv_seq_r <= peer_r;
          end else if (back <= 16'd32) begin
            hist_r <= hist_r | (32'd1 << (back - 16'd1));
          end
        end
      end
      if (cmd.tick_chk && due) begin
        produced_r <= produced_r + 6'd1;
        out_valid <= 1'b1;
        out_seq <= e_seq;
        out_slot <= 5'(scan_slot);
        out_header_ack <= recv_seq_r;
        out_header_ack_mask <= hist_r;
        out_overrun_total <= overrun_r;
        out_last <= 1'b0;
        if (e_retries >= limit_r) begin
          out_kind <= KIND_GIVEUP;
          busy_r[scan_slot] <= 1'b0;
          busy_cnt_r <= busy_cnt_r - CNT_W'(1);
          out_pending_count <= 6'(busy_cnt_r - CNT_W'(1));
        end else begin
          out_kind <= KIND_RETX;
          out_pending_count <= 6'(busy_cnt_r);
        end
      end
      if (cmd.emit_final) begin
        out_valid <= 1'b1;
        out_kind <= (cmd_r == CMD_TICK) ? KIND_TICK : KIND_RECV;
        out_seq <= '0;
        out_slot <= '0;
        out_header_ack <= recv_seq_r;
        out_header_ack_mask <= hist_r;
        out_overrun_total <= overrun_r;
        out_pending_count <= 6'(busy_cnt_r);
        out_last <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/reliable_ack_retransmit_tracker_top.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | command, reliable, peer_seq, ack_number, ack_mask
// out     | output    | out_valid/ out_ready | kind, seq, slot, header_ack, mask, totals, last
// cfg     | input     | cfg_we               | cfg_index, cfg_wdata
// One request at a time. A send passes through the send and output states before the
// next request is accepted; a receive reads and checks each of the 33 ack entries, then
// gives the final result; a tick reads and checks each slot of the 32-entry slot RAM
// with its registered read, then gives the final result. Reset is synchronous and
// clears all tracking state; the slot RAM needs no clear since busy bits guard it.
// A stalled output holds the walk at the next result.
module reliable_ack_retransmit_tracker_top
  import rat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic        in_reliable,
  input  logic [15:0] in_peer_seq,
  input  logic [15:0] in_ack_number,
  input  logic [31:0] in_ack_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [15:0] out_seq,
  output logic [4:0]  out_slot,
  output logic [15:0] out_header_ack,
  output logic [31:0] out_header_ack_mask,
  output logic [31:0] out_overrun_total,
  output logic [5:0]  out_pending_count,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rat_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  rat_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_command(in_command), .in_reliable(in_reliable), .in_peer_seq(in_peer_seq),
    .in_ack_number(in_ack_number), .in_ack_mask(in_ack_mask),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_seq(out_seq), .out_slot(out_slot), .out_header_ack(out_header_ack),
    .out_header_ack_mask(out_header_ack_mask), .out_overrun_total(out_overrun_total),
    .out_pending_count(out_pending_count), .out_last(out_last)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !cmd.do_send && !cmd.emit_final)
    else $error("result overwritten while stalled");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.tick_chk && !cmd.ack_chk)
    else $error("input ready during a walk");
  a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pending_count <= 6'd32)
    else $error("pending count out of range");
`endif

endmodule
